/* rtl/shift_insert_array_table_macros.svh */
// Assertion macros for the checker file.
`ifndef SHIFT_INSERT_ARRAY_TABLE_MACROS_SVH
`define SHIFT_INSERT_ARRAY_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SIAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication whose consequent is checked in the cycle after its condition.
`define SIAT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`endif

/* rtl/siat_pkg.sv */
// ----------------------------------------------------------------------------
// siat_pkg
// Shared types and codes for the shift/insert array table.
// ----------------------------------------------------------------------------
`default_nettype none
package siat_pkg;
    localparam int DEPTH_DEF = 256;

    typedef enum logic [3:0] {
        CMD_APPEND  = 4'd0,
        CMD_INSERT  = 4'd1,
        CMD_DELETE  = 4'd2,
        CMD_GET     = 4'd3,
        CMD_SET     = 4'd4,
        CMD_SEARCH  = 4'd5,
        CMD_SORTINS = 4'd6,
        CMD_MAX     = 4'd7,
        CMD_MIN     = 4'd8,
        CMD_SUM     = 4'd9,
        CMD_REVERSE = 4'd10,
        CMD_ROTL    = 4'd11,
        CMD_ROTR    = 4'd12
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_MISS  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_STEP,
        S_LAST,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

/* rtl/shift_insert_array_table.sv */
// Commands that need no walk (append, set, delete of the last entry) and errors found when
// an item is taken go straight to the done state; get reads its entry, then finishes.
// Walks alternate a read state and a step state for each entry visited, then an optional
// last write and the done state; reverse reads both words of a pair, then writes them back.
// One item at a time: in_ready comes back right after the edge that takes the result.
// Reset clears the fill count and the control state; entries are undefined.
// ----------------------------------------------------------------------------
// shift_insert_array_table
// Packed list of signed words in one memory with insert, delete and walks.
// ----------------------------------------------------------------------------
`default_nettype none
module shift_insert_array_table #(
    parameter int DEPTH = siat_pkg::DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [3:0]                cmd,
    input  wire logic [7:0]                position,
    input  wire logic signed [31:0]        data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [2:0]                     status,
    output logic signed [31:0]             value,
    output logic [7:0]                     found_at,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // Width that holds both the position field and the fill count.
    localparam int PW = (CW > 8) ? CW : 8;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata;
    logic [AW-1:0] raddr, waddr;
    logic          rd_en, wr_en;
    logic [31:0]   wdata;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= wdata;
        if (rd_en)
            rdata <= mem[raddr];
    end

    siat_pkg::state_t state_reg, state_next;
    logic [3:0]   cmd_reg, cmd_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [31:0]  dat_reg, dat_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] i_reg, i_next;     // walk index (entry being read)
    logic [CW-1:0] j_reg, j_next;     // second index for reverse
    logic [31:0]  acc_reg, acc_next;  // carried word / accumulator
    logic         ph_reg, ph_next;    // reverse sub-phase
    logic [2:0]   st_reg, st_next;
    logic [31:0]  val_reg, val_next;
    logic [7:0]   fnd_reg, fnd_next;
    logic         ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= siat_pkg::S_IDLE;
            fill_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        dat_reg <= dat_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        acc_reg <= acc_next;
        ph_reg  <= ph_next;
        st_reg  <= st_next;
        val_reg <= val_next;
        fnd_reg <= fnd_next;
    end

    assign in_ready  = (state_reg == siat_pkg::S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign value     = val_reg;
    assign found_at  = fnd_reg;
    assign count     = fill_reg;

    function automatic logic sgt(input logic [31:0] a, input logic [31:0] b);
        sgt = $signed(a) > $signed(b);
    endfunction

    always_comb
    begin
        logic [CW-1:0] lastn;
        state_next = state_reg;
        cmd_next = cmd_reg; pos_next = pos_reg; dat_next = dat_reg;
        fill_next = fill_reg; i_next = i_reg; j_next = j_reg;
        acc_next = acc_reg; ph_next = ph_reg; st_next = st_reg;
        val_next = val_reg; fnd_next = fnd_reg; ov_next = ov_reg;
        rd_en = 1'b0; wr_en = 1'b0;
        raddr = i_reg[AW-1:0]; waddr = i_reg[AW-1:0]; wdata = dat_reg;
        lastn = fill_reg - CW'(1);
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            siat_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next = cmd; pos_next = CW'(position); dat_next = data;
                    st_next = siat_pkg::ST_OK; val_next = '0; fnd_next = '0;
                    ph_next = 1'b0;
                    state_next = siat_pkg::S_DONE;
                    case (cmd)
                        siat_pkg::CMD_APPEND, siat_pkg::CMD_SORTINS:
                            if (fill_reg >= CW'(DEPTH))
                                st_next = siat_pkg::ST_FULL;
                            else if (cmd == siat_pkg::CMD_APPEND
                                     || fill_reg == '0)
                            begin
                                wr_en = 1'b1; waddr = fill_reg[AW-1:0];
                                wdata = data; fill_next = fill_reg + CW'(1);
                            end
                            else
                            begin
                                i_next = lastn; state_next = siat_pkg::S_READ;
                            end
                        siat_pkg::CMD_INSERT:
                            if (PW'(position) >= PW'(fill_reg))
                                st_next = siat_pkg::ST_RANGE;
                            else if (fill_reg >= CW'(DEPTH))
                                st_next = siat_pkg::ST_FULL;
                            else
                            begin
                                i_next = lastn; state_next = siat_pkg::S_READ;
                            end
                        siat_pkg::CMD_DELETE, siat_pkg::CMD_GET, siat_pkg::CMD_SET:
                            if (PW'(position) >= PW'(fill_reg))
                                st_next = siat_pkg::ST_RANGE;
                            else if (cmd == siat_pkg::CMD_SET)
                            begin
                                wr_en = 1'b1; waddr = AW'(position);
                                wdata = data;
                            end
                            else if (cmd == siat_pkg::CMD_DELETE
                                     && CW'(position) == lastn)
                                fill_next = lastn;
                            else
                            begin
                                i_next = (cmd == siat_pkg::CMD_GET) ? CW'(position)
                                         : CW'(position) + CW'(1);
                                state_next = siat_pkg::S_READ;
                            end
                        siat_pkg::CMD_SEARCH:
                            if (fill_reg == '0) st_next = siat_pkg::ST_MISS;
                            else
                            begin
                                i_next = '0; state_next = siat_pkg::S_READ;
                            end
                        siat_pkg::CMD_MAX, siat_pkg::CMD_MIN, siat_pkg::CMD_ROTL,
                        siat_pkg::CMD_ROTR:
                            if (fill_reg == '0) st_next = siat_pkg::ST_EMPTY;
                            else
                            begin
                                i_next = (cmd == siat_pkg::CMD_ROTR) ? lastn : '0;
                                state_next = siat_pkg::S_READ;
                            end
                        siat_pkg::CMD_SUM:
                            if (fill_reg != '0)
                            begin
                                i_next = '0; acc_next = '0;
                                state_next = siat_pkg::S_READ;
                            end
                        siat_pkg::CMD_REVERSE:
                            if (fill_reg > CW'(1))
                            begin
                                i_next = '0; j_next = lastn;
                                state_next = siat_pkg::S_READ;
                            end
                        default: ;
                    endcase
                end
            end
            siat_pkg::S_READ:
            begin
                // Issue a read of entry i (or j during the reverse second phase).
                rd_en = 1'b1;
                raddr = ph_reg ? j_reg[AW-1:0] : i_reg[AW-1:0];
                state_next = siat_pkg::S_STEP;
            end
            siat_pkg::S_STEP:
            begin
                state_next = siat_pkg::S_READ;
                case (cmd_reg)
                    siat_pkg::CMD_GET:
                    begin
                        val_next = rdata; state_next = siat_pkg::S_DONE;
                    end
                    siat_pkg::CMD_INSERT:
                    begin
                        // Move entry i up one; at the position drop in the item.
                        wr_en = 1'b1; waddr = AW'(i_reg + CW'(1)); wdata = rdata;
                        if (i_reg == pos_reg)
                            state_next = siat_pkg::S_LAST;
                        else
                            i_next = i_reg - CW'(1);
                    end
                    siat_pkg::CMD_SORTINS:
                    begin
                        if (sgt(rdata, dat_reg))
                        begin
                            wr_en = 1'b1; waddr = AW'(i_reg + CW'(1)); wdata = rdata;
                            if (i_reg == '0)
                            begin
                                pos_next = '0; state_next = siat_pkg::S_LAST;
                            end
                            else
                                i_next = i_reg - CW'(1);
                        end
                        else
                        begin
                            pos_next = i_reg + CW'(1); state_next = siat_pkg::S_LAST;
                        end
                    end
                    siat_pkg::CMD_DELETE:
                    begin
                        wr_en = 1'b1; waddr = AW'(i_reg - CW'(1)); wdata = rdata;
                        if (i_reg == lastn)
                        begin
                            fill_next = lastn; state_next = siat_pkg::S_DONE;
                        end
                        else
                            i_next = i_reg + CW'(1);
                    end
                    siat_pkg::CMD_SEARCH:
                        if (rdata == dat_reg)
                        begin
                            fnd_next = 8'(i_reg); state_next = siat_pkg::S_DONE;
                        end
                        else if (i_reg == lastn)
                        begin
                            st_next = siat_pkg::ST_MISS; state_next = siat_pkg::S_DONE;
                        end
                        else
                            i_next = i_reg + CW'(1);
                    siat_pkg::CMD_MAX, siat_pkg::CMD_MIN, siat_pkg::CMD_SUM:
                    begin
                        if (cmd_reg == siat_pkg::CMD_SUM)
                            acc_next = acc_reg + rdata;
                        else if (i_reg == '0
                                 || (cmd_reg == siat_pkg::CMD_MAX && sgt(rdata, acc_reg))
                                 || (cmd_reg == siat_pkg::CMD_MIN && sgt(acc_reg, rdata)))
                            acc_next = rdata;
                        if (i_reg == lastn)
                        begin
                            val_next = acc_next; state_next = siat_pkg::S_DONE;
                        end
                        else
                            i_next = i_reg + CW'(1);
                    end
                    siat_pkg::CMD_ROTL:
                    begin
                        if (i_reg == '0)
                            acc_next = rdata;
                        else
                        begin
                            wr_en = 1'b1; waddr = AW'(i_reg - CW'(1)); wdata = rdata;
                        end
                        if (i_reg == lastn)
                        begin
                            pos_next = lastn; dat_next = acc_next;
                            state_next = siat_pkg::S_LAST;
                        end
                        else
                            i_next = i_reg + CW'(1);
                    end
                    siat_pkg::CMD_ROTR:
                    begin
                        if (i_reg == lastn)
                            acc_next = rdata;
                        else
                        begin
                            wr_en = 1'b1; waddr = AW'(i_reg + CW'(1)); wdata = rdata;
                        end
                        if (i_reg == '0)
                        begin
                            pos_next = '0; dat_next = acc_next;
                            state_next = siat_pkg::S_LAST;
                        end
                        else
                            i_next = i_reg - CW'(1);
                    end
                    siat_pkg::CMD_REVERSE:
                        if (!ph_reg)
                        begin
                            acc_next = rdata; ph_next = 1'b1;
                        end
                        else
                        begin
                            // Swap: j's word goes to i now, i's word to j next.
                            wr_en = 1'b1; waddr = i_reg[AW-1:0]; wdata = rdata;
                            pos_next = j_reg; dat_next = acc_reg;
                            state_next = siat_pkg::S_WAIT;
                        end
                    default: state_next = siat_pkg::S_DONE;
                endcase
            end
            siat_pkg::S_WAIT:
            begin
                wr_en = 1'b1; waddr = pos_reg[AW-1:0]; wdata = dat_reg;
                ph_next = 1'b0;
                i_next = i_reg + CW'(1); j_next = j_reg - CW'(1);
                if (i_reg + CW'(1) >= j_reg - CW'(1))
                    state_next = siat_pkg::S_DONE;
                else
                    state_next = siat_pkg::S_READ;
            end
            siat_pkg::S_LAST:
            begin
                wr_en = 1'b1; waddr = pos_reg[AW-1:0]; wdata = dat_reg;
                if (cmd_reg == siat_pkg::CMD_INSERT || cmd_reg == siat_pkg::CMD_SORTINS)
                    fill_next = fill_reg + CW'(1);
                state_next = siat_pkg::S_DONE;
            end
            siat_pkg::S_DONE:
            begin
                ov_next = 1'b1;
                state_next = siat_pkg::S_IDLE;
            end
            default: state_next = siat_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/siat_checker.sv */
// ----------------------------------------------------------------------------
// siat_checker
// Port-level checks for the shift/insert array table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shift_insert_array_table_macros.svh"
module siat_checker #(
    parameter int CW = 9
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire logic [2:0]    status,
    input wire logic [CW-1:0] count
);
    // One item at a time: no new item while a result is pending.
    `SIAT_ASSERT(a_no_accept_pending, clk, rst_n, out_valid |-> !in_ready, "accept pending")
    // An accepted item makes the block busy on the next cycle.
    `SIAT_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
    // A stalled result keeps its count.
    `SIAT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(count),
                      "count changed under stall")
    // Count moves only just before its result appears.
    `SIAT_ASSERT_NEXT(a_count_step, clk, rst_n, count != $past(count), $rose(out_valid),
                      "count moved without result")
    // Status codes stay in range.
    `SIAT_ASSERT(a_status, clk, rst_n, out_valid |-> (status <= 3'd4), "bad status code")
endmodule
bind shift_insert_array_table siat_checker #(.CW($clog2(DEPTH + 1))) u_siat_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .count(count)
);
`default_nettype wire
